### rtl/fcal_pkg.sv
// Shared types, constants and the factory calibration table of the force/torque calibrator.
package fcal_pkg;

  localparam int AXES           = 6;
  localparam int CHANNELS       = 6;
  localparam int NAX            = (AXES < CHANNELS) ? AXES : CHANNELS;
  localparam int COEF_FRAC_BITS = 16;
  localparam int COEF_COUNT     = CHANNELS * CHANNELS;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 24;
  localparam int IDX_W    = 6;
  localparam int OUT_W    = 25;
  localparam int CFG_W    = 1;
  localparam int DIFF_W   = SAMPLE_W + 1;
  localparam int PROD_W   = COEF_W + DIFF_W;
  localparam int ACC_W    = PROD_W + $clog2(CHANNELS);
  localparam int SQ_W     = 2 * OUT_W - 1;
  localparam int SUM_W    = SQ_W + 3;
  localparam int ROOT_W   = SUM_W / 2;
  localparam int CNT_W    = $clog2(CHANNELS);

  localparam longint OUT_MAX  = (64'sd1 <<< (OUT_W - 1)) - 1;
  localparam longint OUT_MIN  = -(64'sd1 <<< (OUT_W - 1));
  localparam longint COEF_MAX = (64'sd1 <<< (COEF_W - 1)) - 1;
  localparam longint COEF_MIN = -(64'sd1 <<< (COEF_W - 1));

  typedef enum logic [1:0] {
    ACT_TARE    = 2'd0,
    ACT_MEASURE = 2'd1,
    ACT_LOAD    = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_SQUARE,
    ST_ROOT_GO,
    ST_ROOT,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic             tare_we;
    logic             coef_we;
    logic             meas_load;
    logic             mac_issue;
    logic [CNT_W-1:0] mac_row;
    logic [CNT_W-1:0] mac_col;
    logic             mac_first;
    logic             mac_last;
    logic             sq_mul;
    logic             sq_acc;
    logic             sq_clr;
    logic [CNT_W-1:0] sq_sel;
    logic             root_start;
    logic             out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic root_done;
    logic out_free;
  } dp_status_t;

  // Factory matrix (Q.16), rescaled to COEF_FRAC_BITS and saturated to COEF_W bits.
  function automatic logic signed [COEF_W-1:0] reset_coef(input logic [IDX_W-1:0] idx);
    longint t;
    case (idx)
      6'd0:    t = 3238;
      6'd1:    t = -6034;
      6'd2:    t = -1798;
      6'd3:    t = -225143;
      6'd4:    t = 4936;
      6'd5:    t = 223452;
      6'd6:    t = -920;
      6'd7:    t = 261747;
      6'd8:    t = -1176;
      6'd9:    t = -135220;
      6'd10:   t = -3423;
      6'd11:   t = -123566;
      6'd12:   t = 247261;
      6'd13:   t = 7753;
      6'd14:   t = 255128;
      6'd15:   t = -2880;
      6'd16:   t = 243607;
      6'd17:   t = 105;
      6'd18:   t = -898;
      6'd19:   t = 3058159;
      6'd20:   t = 1370197;
      6'd21:   t = -1595542;
      6'd22:   t = -1430336;
      6'd23:   t = -1444821;
      6'd24:   t = -1638355;
      6'd25:   t = 13488;
      6'd26:   t = 841442;
      6'd27:   t = 2620250;
      6'd28:   t = 703258;
      6'd29:   t = -2605534;
      6'd30:   t = -4757;
      6'd31:   t = 1005418;
      6'd32:   t = 3154;
      6'd33:   t = 1003056;
      6'd34:   t = 31825;
      6'd35:   t = 982543;
      default: t = 0;
    endcase
    if (COEF_FRAC_BITS >= 16) begin
      t = t <<< (COEF_FRAC_BITS - 16);
    end else begin
      // round half up, then floor shift
      t = (t + (64'sd1 <<< (15 - COEF_FRAC_BITS))) >>> (16 - COEF_FRAC_BITS);
    end
    if (t > COEF_MAX) t = COEF_MAX;
    if (t < COEF_MIN) t = COEF_MIN;
    return t[COEF_W-1:0];
  endfunction

endpackage

### rtl/fcal_isqrt.sv
// Bit-serial integer square root, one result bit per cycle.
module fcal_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [fcal_pkg::SUM_W-1:0]  radicand_i,
  output logic                        done_o,
  output logic [fcal_pkg::ROOT_W-1:0] root_o
);
  import fcal_pkg::*;

  localparam int REM_W   = ROOT_W + 3;
  localparam int STEP_W  = $clog2(ROOT_W);

  logic              busy_q;
  logic [STEP_W-1:0] step_q;
  logic [SUM_W-1:0]  n_q;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [REM_W-1:0]  rem_sh, trial;

  always_comb begin
    rem_sh = {rem_q[REM_W-3:0], n_q[SUM_W-1:SUM_W-2]};
    trial  = {{(REM_W-ROOT_W-2){1'b0}}, root_q, 2'b01};
    if (rem_sh >= trial) begin
      rem_d  = rem_sh - trial;
      root_d = {root_q[ROOT_W-2:0], 1'b1};
    end else begin
      rem_d  = rem_sh;
      root_d = {root_q[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 1'b1;
      if (done_o) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q    <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      n_q    <= n_q << 2;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign done_o = busy_q && (step_q == STEP_W'(ROOT_W - 1));
  assign root_o = root_q;

endmodule

### rtl/fcal_dp.sv
// Datapath: sample and bias registers, coefficient memory, shared MAC, squares, root, output word.
module fcal_dp (
  input  logic                                                   clk_i,
  input  logic                                                   rst_ni,
  input  fcal_pkg::dp_cmd_t                                      cmd_i,
  output fcal_pkg::dp_status_t                                   status_o,
  input  logic                                                   mag_en_i,
  input  logic [fcal_pkg::CHANNELS-1:0][fcal_pkg::SAMPLE_W-1:0]  ch_i,
  input  logic [fcal_pkg::IDX_W-1:0]                             coef_index_i,
  input  logic [fcal_pkg::COEF_W-1:0]                            coef_value_i,
  input  logic                                                   out_stall_i,
  output logic                                                   out_valid_o,
  output logic [fcal_pkg::CHANNELS-1:0][fcal_pkg::OUT_W-1:0]     res_o,
  output logic [fcal_pkg::OUT_W-1:0]                             magnitude_o
);
  import fcal_pkg::*;

  logic [SAMPLE_W-1:0] ch_q   [CHANNELS];
  logic [SAMPLE_W-1:0] bias_q [CHANNELS];

  logic [COEF_W-1:0]     mem [COEF_COUNT];
  logic [COEF_COUNT-1:0] mem_vld_q;
  logic [IDX_W-1:0]      rd_addr, rd_idx_q;
  logic [COEF_W-1:0]     rd_data_q;
  logic                  rd_vld_q;
  logic                  coef_wr;

  logic signed [DIFF_W-1:0] diff_d, diff_q;
  logic                     s1_v_q, s1_first_q, s1_last_q;
  logic [CNT_W-1:0]         s1_row_q;
  logic                     s2_v_q, s2_first_q, s2_last_q;
  logic [CNT_W-1:0]         s2_row_q;
  logic signed [COEF_W-1:0] coef_sel;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [ACC_W-1:0]  acc_q, acc_sum, acc_shift;
  logic signed [OUT_W-1:0]  sat_val;
  logic signed [OUT_W-1:0]  res_q [CHANNELS];

  logic signed [2*OUT_W-1:0] sq_full;
  logic [SQ_W-1:0]           sq_q;
  logic [SUM_W-1:0]          sum_q;
  logic                      root_done;
  logic [ROOT_W-1:0]         root;

  logic                      out_valid_q;
  logic [OUT_W-1:0]          out_res_q [CHANNELS];
  logic [OUT_W-1:0]          out_mag_q;

  // bias and latched samples
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) bias_q[c] <= '0;
    end else if (cmd_i.tare_we) begin
      for (int c = 0; c < CHANNELS; c++) bias_q[c] <= ch_i[c];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.meas_load) begin
      for (int c = 0; c < CHANNELS; c++) ch_q[c] <= ch_i[c];
    end
  end

  // coefficient memory; an entry never loaded reads as the factory value
  assign coef_wr = cmd_i.coef_we && (coef_index_i < IDX_W'(COEF_COUNT));
  assign rd_addr = IDX_W'(int'(cmd_i.mac_row) * CHANNELS + int'(cmd_i.mac_col));

  always_ff @(posedge clk_i) begin
    if (coef_wr) mem[coef_index_i] <= coef_value_i;
    rd_data_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_vld_q <= '0;
    end else if (coef_wr) begin
      mem_vld_q[coef_index_i] <= 1'b1;
    end
  end

  // MAC pipeline: read / multiply / accumulate
  assign diff_d = $signed({ch_q[cmd_i.mac_col][SAMPLE_W-1], ch_q[cmd_i.mac_col]})
                - $signed({bias_q[cmd_i.mac_col][SAMPLE_W-1], bias_q[cmd_i.mac_col]});

  always_ff @(posedge clk_i) begin
    rd_vld_q <= mem_vld_q[rd_addr];
    rd_idx_q <= rd_addr;
    diff_q   <= diff_d;
    s1_first_q <= cmd_i.mac_first;
    s1_last_q  <= cmd_i.mac_last;
    s1_row_q   <= cmd_i.mac_row;
    s2_first_q <= s1_first_q;
    s2_last_q  <= s1_last_q;
    s2_row_q   <= s1_row_q;
    prod_q     <= prod_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      s1_v_q <= cmd_i.mac_issue;
      s2_v_q <= s1_v_q;
    end
  end

  always_comb begin
    coef_sel  = rd_vld_q ? $signed(rd_data_q) : reset_coef(rd_idx_q);
    prod_d    = PROD_W'(coef_sel) * PROD_W'(diff_q);
    acc_sum   = (s2_first_q ? ACC_W'(0) : acc_q) + ACC_W'(prod_q);
    acc_shift = acc_sum >>> COEF_FRAC_BITS;
    if (acc_shift > ACC_W'(OUT_MAX))      sat_val = OUT_W'(OUT_MAX);
    else if (acc_shift < ACC_W'(OUT_MIN)) sat_val = OUT_W'(OUT_MIN);
    else                                  sat_val = acc_shift[OUT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (s2_v_q) begin
      acc_q <= acc_sum;
      if (s2_last_q) res_q[s2_row_q] <= sat_val;
    end
    for (int r = 0; r < CHANNELS; r++) begin
      if (r >= NAX) res_q[r] <= '0;
    end
  end

  // sum of squared forces
  assign sq_full = res_q[cmd_i.sq_sel] * res_q[cmd_i.sq_sel];

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_mul) sq_q <= sq_full[SQ_W-1:0];
    if (cmd_i.sq_acc) begin
      if (cmd_i.sq_clr) sum_q <= SUM_W'(sq_q);
      else              sum_q <= sum_q + SUM_W'(sq_q);
    end
  end

  fcal_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.root_start),
    .radicand_i (sum_q),
    .done_o     (root_done),
    .root_o     (root)
  );

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      for (int r = 0; r < CHANNELS; r++) out_res_q[r] <= res_q[r];
      out_mag_q <= mag_en_i ? OUT_W'(root) : '0;
    end
  end

  always_comb begin
    for (int r = 0; r < CHANNELS; r++) res_o[r] = out_res_q[r];
  end

  assign magnitude_o = out_mag_q;
  assign out_valid_o = out_valid_q;

  assign status_o.pipe_busy = s1_v_q || s2_v_q;
  assign status_o.root_done = root_done;
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

endmodule

### rtl/fcal_ctrl.sv
// Controller: accepts words, sequences the MAC sweep, squares and root (with magnitude on) and output load.
module fcal_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           action_i,
  output logic                 in_stall_o,
  input  logic                 mag_en_i,
  input  fcal_pkg::dp_status_t status_i,
  output fcal_pkg::dp_cmd_t    cmd_o
);
  import fcal_pkg::*;

  ctrl_state_e      state_q, state_d;
  logic [CNT_W-1:0] row_q, row_d, col_q, col_d;
  logic [1:0]       step_q, step_d;
  logic             accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= '0;
      col_q   <= '0;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      step_q  <= step_d;
    end
  end

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    col_d   = col_q;
    step_d  = step_q;
    cmd_o   = '0;
    cmd_o.mac_row = row_q;
    cmd_o.mac_col = col_q;
    cmd_o.sq_sel  = CNT_W'(step_q);

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (action_i)
            ACT_TARE: cmd_o.tare_we = 1'b1;
            ACT_LOAD: cmd_o.coef_we = 1'b1;
            ACT_MEASURE: begin
              cmd_o.meas_load = 1'b1;
              row_d   = '0;
              col_d   = '0;
              state_d = ST_MAC;
            end
            default: ;
          endcase
        end
      end
      ST_MAC: begin
        cmd_o.mac_issue = 1'b1;
        cmd_o.mac_first = (col_q == '0);
        cmd_o.mac_last  = (col_q == CNT_W'(NAX - 1));
        if (col_q == CNT_W'(NAX - 1)) begin
          col_d = '0;
          if (row_q == CNT_W'(NAX - 1)) begin
            state_d = ST_DRAIN;
          end else begin
            row_d = row_q + 1'b1;
          end
        end else begin
          col_d = col_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          step_d  = '0;
          state_d = mag_en_i ? ST_SQUARE : ST_DONE;
        end
      end
      ST_SQUARE: begin
        // squares of Fx, Fy, Fz issued on steps 0..2, summed on steps 1..3
        cmd_o.sq_mul = (step_q != 2'd3);
        cmd_o.sq_acc = (step_q != 2'd0);
        cmd_o.sq_clr = (step_q == 2'd1);
        step_d = step_q + 1'b1;
        if (step_q == 2'd3) state_d = ST_ROOT_GO;
      end
      ST_ROOT_GO: begin
        cmd_o.root_start = 1'b1;
        state_d = ST_ROOT;
      end
      ST_ROOT: begin
        if (status_i.root_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

### rtl/six_axis_force_torque_calibrator_core.sv
// Tare and coefficient-load words are taken while idle and give no result.
// Measure: the shared one-product-per-cycle MAC forms NAX*NAX products, then drains its read,
// multiply and accumulate stages; magnitude adds four square steps, a start and a 26-bit root.
// Input: the next word is accepted once the result is loaded into the output register, which
// waits while the output stalls; tare and load words are taken every cycle while idle.
// Reset (async, low): bias zero, magnitude off, coefficient store back to factory matrix.
module six_axis_force_torque_calibrator_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [1:0]                             action_i,
  input  logic signed [fcal_pkg::SAMPLE_W-1:0]   ch0_i,
  input  logic signed [fcal_pkg::SAMPLE_W-1:0]   ch1_i,
  input  logic signed [fcal_pkg::SAMPLE_W-1:0]   ch2_i,
  input  logic signed [fcal_pkg::SAMPLE_W-1:0]   ch3_i,
  input  logic signed [fcal_pkg::SAMPLE_W-1:0]   ch4_i,
  input  logic signed [fcal_pkg::SAMPLE_W-1:0]   ch5_i,
  input  logic [fcal_pkg::IDX_W-1:0]             coef_index_i,
  input  logic signed [fcal_pkg::COEF_W-1:0]     coef_value_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [fcal_pkg::OUT_W-1:0]      force_x_o,
  output logic signed [fcal_pkg::OUT_W-1:0]      force_y_o,
  output logic signed [fcal_pkg::OUT_W-1:0]      force_z_o,
  output logic signed [fcal_pkg::OUT_W-1:0]      torque_x_o,
  output logic signed [fcal_pkg::OUT_W-1:0]      torque_y_o,
  output logic signed [fcal_pkg::OUT_W-1:0]      torque_z_o,
  output logic [fcal_pkg::OUT_W-1:0]             magnitude_o,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [fcal_pkg::CFG_W-1:0]             cfg_data_i
);
  import fcal_pkg::*;

  logic                                 mag_en_q;
  dp_cmd_t                              cmd;
  dp_status_t                           status;
  logic [CHANNELS-1:0][SAMPLE_W-1:0]    ch;
  logic [CHANNELS-1:0][OUT_W-1:0]       res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_en_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mag_en_q <= cfg_data_i[0];
    end
  end

  assign ch[0] = ch0_i;
  assign ch[1] = ch1_i;
  assign ch[2] = ch2_i;
  assign ch[3] = ch3_i;
  assign ch[4] = ch4_i;
  assign ch[5] = ch5_i;

  fcal_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .in_stall_o (in_stall_o),
    .mag_en_i   (mag_en_q),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  fcal_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .mag_en_i     (mag_en_q),
    .ch_i         (ch),
    .coef_index_i (coef_index_i),
    .coef_value_i (coef_value_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .res_o        (res),
    .magnitude_o  (magnitude_o)
  );

  assign force_x_o  = res[0];
  assign force_y_o  = res[1];
  assign force_z_o  = res[2];
  assign torque_x_o = res[3];
  assign torque_y_o = res[4];
  assign torque_z_o = res[5];

  // a finished measure always leaves a word in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> out_valid_o)
    else $error("returned to idle without loading a result word");

  // an accepted measure word blocks the input until its result is loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (action_i == ACT_MEASURE)) |=> in_stall_o)
    else $error("measure word accepted without starting the sequence");

endmodule
